// ===== hdl/mtim_pkg.sv =====
// package for the message topic id map: word types, operation codes, defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtim_pkg;

    localparam int ENTRIES_DEF = 32;

    localparam logic [3:0] MAX_INFLIGHT_RST = 4'd10;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] TYPE_SHORT   = 2'd2;
    localparam logic [1:0] TYPE_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] msg_id;
        logic [15:0] topic_id;
        logic [1:0]  topic_type;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [15:0] found_topic_id;
        logic [1:0]  found_type;
        logic [5:0]  entry_total;
    } t_out_word;

    // one stored entry
    typedef struct packed {
        logic [15:0] msg_id;
        logic [15:0] topic_id;
        logic [1:0]  topic_type;
    } t_slot;

endpackage

`default_nettype wire

// ===== hdl/mtim_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mtim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/message_topic_id_map.sv =====
// message topic id map: keyed table of in-flight message ids, scanned from ram
// depends on mtim_pkg and mtim_ram
//
//  port group          dir  handshake                   payload
//  input word          in   i_in_valid / o_in_ready      i_in_data  (t_in_word)
//  result word         out  o_out_valid / i_out_ready    o_out_data (t_out_word)
//  limit register      in   i_cfg_we                     i_cfg_data (max_inflight)
//
// add, erase and lookup read every entry of the ram once, one address a cycle;
// clear skips the scan. a new word is accepted only after the last one is done.
// reset (synchronous, active low) empties the table through the valid flops
// and loads the limit with 10. a stalled result holds the finished word in the
// output register; the next word is accepted but waits before write-back.
`timescale 1ns / 1ps
`default_nettype none

module message_topic_id_map
    import mtim_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data,
    input  wire logic      i_cfg_we,
    input  wire logic [3:0] i_cfg_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]         r_state;
    logic [3:0]         r_max_inflight;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]      r_count;
    t_in_word           r_item;
    logic [AW-1:0]      r_addr;
    logic               r_rd_pend;
    logic [AW-1:0]      r_rd_idx;
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic [15:0]        r_hit_tid;
    logic [1:0]         r_hit_type;
    logic               r_free_found;
    logic [AW-1:0]      r_free_idx;
    logic               r_out_valid;
    t_out_word          r_out_data;

    t_slot              ram_q;
    t_slot              ram_wdata;
    logic               ram_re;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;

    logic               in_take;
    logic               fin_go;
    logic               slot_valid;
    logic               over_limit;
    logic               refuse;
    logic               n_ok;
    logic [CW-1:0]      n_count;
    logic [CW+5:0]      cnt_ext;
    logic [CW+5:0]      lim_ext;
    logic [CW+5:0]      total_ext;
    t_out_word          n_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_take     = i_in_valid && o_in_ready;
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign ram_re     = (r_state == S_SCAN);
    assign slot_valid = r_valid[r_rd_idx];

    mtim_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // limit test: count greater than twice max_inflight
    assign cnt_ext    = {6'd0, r_count};
    assign lim_ext    = {(CW + 1)'(0), r_max_inflight, 1'b0};
    assign over_limit = cnt_ext > lim_ext;
    assign refuse     = over_limit || (r_item.topic_type == TYPE_INVALID)
                        || ((r_item.topic_id == 16'd0) && (r_item.topic_type != TYPE_SHORT));

    assign ram_wdata.msg_id     = r_item.msg_id;
    assign ram_wdata.topic_id   = r_item.topic_id;
    assign ram_wdata.topic_type = r_item.topic_type;
    assign ram_waddr            = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        n_ok    = 1'b0;
        n_count = r_count;
        ram_we  = 1'b0;
        case (r_item.op)
            OP_ADD: begin
                if (!refuse && (r_hit || r_free_found)) begin
                    n_ok   = 1'b1;
                    ram_we = fin_go;
                    if (!r_hit) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            OP_ERASE: begin
                if (r_hit) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            OP_LOOKUP: begin
                n_ok = r_hit;
            end
            OP_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign total_ext = {6'd0, n_count};

    always_comb begin
        n_out.ok             = n_ok;
        n_out.found_topic_id = 16'd0;
        n_out.found_type     = 2'd0;
        n_out.entry_total    = total_ext[5:0];
        if ((r_item.op == OP_LOOKUP) && r_hit) begin
            n_out.found_topic_id = r_hit_tid;
            n_out.found_type     = r_hit_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_max_inflight <= MAX_INFLIGHT_RST;
            r_valid        <= '0;
            r_count        <= '0;
            r_rd_pend      <= 1'b0;
            r_hit          <= 1'b0;
            r_free_found   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_inflight <= i_cfg_data;
            end

            // a finishing word refills the output register in the same cycle
            if (o_out_valid && i_out_ready && !fin_go) begin
                r_out_valid <= 1'b0;
            end

            // compare the word returned by the ram
            if (r_rd_pend) begin
                if (slot_valid && (ram_q.msg_id == r_item.msg_id)) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_rd_idx;
                    r_hit_tid  <= ram_q.topic_id;
                    r_hit_type <= ram_q.topic_type;
                end
                if (!slot_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_item       <= i_in_data;
                        r_addr       <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= (i_in_data.op == OP_CLEAR) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= 1'b1;
                    r_rd_idx  <= r_addr;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_LAST: begin
                    r_rd_pend <= 1'b0;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= n_out;
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                        case (r_item.op)
                            OP_ADD: begin
                                if (ram_we && !r_hit) begin
                                    r_valid[r_free_idx] <= 1'b1;
                                end
                            end
                            OP_ERASE: begin
                                if (r_hit) begin
                                    r_valid[r_hit_idx] <= 1'b0;
                                end
                            end
                            OP_CLEAR: begin
                                r_valid <= '0;
                            end
                            default: begin
                                r_valid <= r_valid;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
